>>> design/wbm_pkg.sv
package wbm_pkg;

  localparam int MAX_WORDS    = 16;
  localparam int MAX_WORD_LEN = 8;
  localparam int POS_BITS     = 20;

  localparam int WORD_W     = 8 * MAX_WORD_LEN;
  localparam int LEN_W      = 4;
  localparam int CNT_W      = $clog2(MAX_WORDS + 1);
  localparam int IDX_W      = CNT_W;
  localparam int DICT_AW    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int HIST_DEPTH = MAX_WORDS * MAX_WORD_LEN;
  localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int SPAN_W     = $clog2(HIST_DEPTH + 1);
  localparam int PH_W       = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
  localparam int NO_WORD    = MAX_WORDS;

  localparam logic [POS_BITS-1:0] POS_MAX = '1;

  localparam logic [1:0] MODE_CLEAR   = 2'd0;
  localparam logic [1:0] MODE_LOAD    = 2'd1;
  localparam logic [1:0] MODE_TEXT    = 2'd2;
  localparam logic [1:0] MODE_RESTART = 2'd3;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_DICT_FULL = 2'd1;
  localparam logic [1:0] STATUS_TEXT_LONG = 2'd2;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [SPAN_W-1:0] span_t;
  typedef cnt_t [MAX_WORDS-1:0] cnt_vec_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [WORD_W-1:0] word;
    logic [7:0]        text_byte;
  } item_t;

  typedef struct packed {
    logic                match_found;
    logic [POS_BITS-1:0] match_start;
    logic [1:0]          status;
    logic [CNT_W-1:0]    distinct_words;
  } result_t;

  typedef struct packed {
    logic clear;
    logic load;
  } dict_ctl_t;

  typedef struct packed {
    logic restart;
    logic step;
    logic dec_en;
  } win_ctl_t;

endpackage

>>> design/wbm_ram.sv
module wbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first: a same-address read returns the old word; the write shows up on a later read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/wbm_dict.sv
module wbm_dict (
  input  logic                      clk,
  input  logic                      rst,
  input  wbm_pkg::dict_ctl_t        ctl,
  input  logic [wbm_pkg::WORD_W-1:0] key,
  output wbm_pkg::idx_t             cur,
  output wbm_pkg::cnt_t             distinct,
  output wbm_pkg::cnt_t             distinct_next,
  output wbm_pkg::cnt_t             total,
  output logic                      full,
  output wbm_pkg::cnt_vec_t         need
);
  import wbm_pkg::*;

  logic [WORD_W-1:0] entries [MAX_WORDS];
  logic              load_ok;
  logic              add_new;

  // parallel compare, lowest matching slot wins
  always_comb begin
    cur = IDX_W'(NO_WORD);
    for (int k = MAX_WORDS - 1; k >= 0; k--) begin
      if ((IDX_W'(k) < distinct) && (entries[k] == key)) begin
        cur = IDX_W'(k);
      end
    end
  end

  assign full    = (total >= CNT_W'(MAX_WORDS));
  assign load_ok = ctl.load && !full;
  assign add_new = load_ok && (cur == IDX_W'(NO_WORD));

  always_comb begin
    if (ctl.clear) begin
      distinct_next = '0;
    end else if (add_new) begin
      distinct_next = distinct + CNT_W'(1);
    end else begin
      distinct_next = distinct;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      distinct <= '0;
      total    <= '0;
    end else begin
      distinct <= distinct_next;
      if (ctl.clear) begin
        total <= '0;
      end else if (load_ok) begin
        total <= total + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (add_new) begin
      entries[distinct[DICT_AW-1:0]] <= key;
      need[distinct[DICT_AW-1:0]]    <= CNT_W'(1);
    end else if (load_ok) begin
      need[cur[DICT_AW-1:0]] <= need[cur[DICT_AW-1:0]] + CNT_W'(1);
    end
  end

endmodule

>>> design/wbm_window.sv
module wbm_window (
  input  logic                     clk,
  input  logic                     rst,
  input  wbm_pkg::win_ctl_t        ctl,
  input  wbm_pkg::idx_t            cur,
  input  wbm_pkg::cnt_vec_t        need,
  input  wbm_pkg::cnt_t            distinct,
  input  logic [wbm_pkg::LEN_W-1:0] m,
  input  wbm_pkg::span_t           span,
  output logic                     sat_hit
);
  import wbm_pkg::*;

  cnt_vec_t             counts [MAX_WORD_LEN];
  cnt_t                 sat    [MAX_WORD_LEN];
  logic [PH_W-1:0]      phase;
  logic [PH_W-1:0]      phase_next;
  logic [HIST_AW-1:0]   wptr;
  logic [HIST_AW-1:0]   wptr_next;
  logic [HIST_AW-1:0]   raddr;
  span_t                wn_ext;
  idx_t                 ram_q;
  idx_t                 byp_data;
  idx_t                 prev;
  logic                 byp_hit;
  cnt_vec_t             row;
  cnt_vec_t             row_next;
  cnt_t                 sat_cur;
  cnt_t                 sat_mid;
  cnt_t                 sat_next;
  cnt_t                 mid_k;
  logic                 sat_dec;
  logic                 sat_inc;
  logic                 dec_k;
  logic                 inc_k;

  // leaving word first, then arriving word, per lane of the phase row
  always_comb begin
    row      = counts[phase];
    sat_cur  = sat[phase];
    prev     = byp_hit ? byp_data : ram_q;
    sat_dec  = 1'b0;
    sat_inc  = 1'b0;
    dec_k    = 1'b0;
    inc_k    = 1'b0;
    mid_k    = '0;
    row_next = row;
    for (int k = 0; k < MAX_WORDS; k++) begin
      dec_k = ctl.dec_en && (prev == IDX_W'(k)) && (row[k] != '0);
      inc_k = (cur == IDX_W'(k));
      if (dec_k && (row[k] == need[k])) begin
        sat_dec = 1'b1;
      end
      mid_k       = row[k] - CNT_W'(dec_k);
      row_next[k] = mid_k + CNT_W'(inc_k);
      if (inc_k && (row_next[k] == need[k])) begin
        sat_inc = 1'b1;
      end
    end
    sat_mid  = (sat_dec && (sat_cur != '0)) ? sat_cur - CNT_W'(1) : sat_cur;
    sat_next = sat_mid + CNT_W'(sat_inc);
  end

  assign sat_hit    = (distinct != '0) && (sat_next == distinct);
  assign phase_next = (LEN_W'(phase) == m - LEN_W'(1)) ? '0 : phase + PH_W'(1);

  always_comb begin
    if (ctl.restart) begin
      wptr_next = '0;
    end else if (ctl.step) begin
      wptr_next = (wptr == HIST_AW'(HIST_DEPTH - 1)) ? '0 : wptr + HIST_AW'(1);
    end else begin
      wptr_next = wptr;
    end
  end

  // history entry that leaves the window on the next word
  assign wn_ext = SPAN_W'(wptr_next);
  assign raddr  = (wn_ext >= span) ? HIST_AW'(wn_ext - span)
                                   : HIST_AW'(wn_ext + SPAN_W'(HIST_DEPTH) - span);

  wbm_ram #(
    .WIDTH (IDX_W),
    .DEPTH (HIST_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ctl.step),
    .waddr (wptr),
    .wdata (cur),
    .raddr (raddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst || ctl.restart) begin
      for (int p = 0; p < MAX_WORD_LEN; p++) begin
        counts[p] <= '0;
        sat[p]    <= '0;
      end
      phase <= '0;
    end else if (ctl.step) begin
      counts[phase] <= row_next;
      sat[phase]    <= sat_next;
      phase         <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr    <= '0;
      byp_hit <= 1'b0;
    end else begin
      wptr    <= wptr_next;
      byp_hit <= ctl.step && (wptr == raddr);
    end
  end

  always_ff @(posedge clk) begin
    byp_data <= cur;
  end

endmodule

>>> design/word_bag_window_matcher.sv
// channel | signals                          | dir | beat
// item    | item_valid item_stall item       | in  | item_valid && !item_stall
// result  | result_valid result_stall result | out | result_valid && !result_stall
// cfg     | cfg_valid cfg_ready cfg_data     | in  | cfg_valid && cfg_ready
//
// One item per cycle sustained while result_stall lets results go; an accepted item
// is held in the input register, then one pass of lookup and window update writes the
// result register. History memory reads are registered, addressed from wptr_next.
// rst (synchronous) empties the dictionary, clears text and window state, word_len=1.
// result_stall holds the result register; with the input register full it stalls the item side.
// cfg_ready is low while an item sits in the input register.
module word_bag_window_matcher (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  wbm_pkg::item_t             item,
  output logic                       result_valid,
  input  logic                       result_stall,
  output wbm_pkg::result_t           result,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [wbm_pkg::LEN_W-1:0]  cfg_data
);
  import wbm_pkg::*;

  item_t               s1;
  logic                s1_valid;
  logic                advance;
  logic                go;
  logic                cfg_we;
  logic [LEN_W-1:0]    word_len;
  logic [LEN_W-1:0]    m;
  logic [LEN_W-1:0]    sh;
  logic [POS_BITS-1:0] text_position;
  logic [POS_BITS-1:0] p_inc;
  logic [POS_BITS-1:0] j;
  logic [POS_BITS-1:0] start;
  logic [WORD_W-1:0]   recent_bytes;
  logic [WORD_W-1:0]   recent_new;
  logic [WORD_W-1:0]   text_key;
  logic [WORD_W-1:0]   load_key;
  logic [WORD_W-1:0]   key;
  logic                is_clear;
  logic                is_load;
  logic                is_text;
  logic                is_restart;
  logic                text_ok;
  logic                complete;
  logic                restart;
  logic                back_ok;
  logic                found;
  logic [1:0]          status;
  span_t               span;
  span_t               back;
  idx_t                cur;
  cnt_t                distinct;
  cnt_t                distinct_next;
  cnt_t                total;
  logic                full;
  cnt_vec_t            need;
  logic                sat_hit;
  dict_ctl_t           dict_ctl;
  win_ctl_t            win_ctl;

  assign advance    = !result_valid || !result_stall;
  assign item_stall = s1_valid && !advance;
  assign go         = s1_valid && advance;
  assign cfg_ready  = !s1_valid;
  assign cfg_we     = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      s1_valid     <= (item_valid && !item_stall) || (s1_valid && !advance);
      result_valid <= go || (result_valid && result_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1 <= item;
    end
  end

  always_comb begin
    is_clear   = 1'b0;
    is_load    = 1'b0;
    is_text    = 1'b0;
    is_restart = 1'b0;
    unique case (s1.mode)
      MODE_CLEAR:   is_clear   = 1'b1;
      MODE_LOAD:    is_load    = 1'b1;
      MODE_TEXT:    is_text    = 1'b1;
      MODE_RESTART: is_restart = 1'b1;
      default:      is_restart = 1'b1;
    endcase
  end

  always_comb begin
    if (word_len == '0) begin
      m = LEN_W'(1);
    end else if (word_len > LEN_W'(MAX_WORD_LEN)) begin
      m = LEN_W'(MAX_WORD_LEN);
    end else begin
      m = word_len;
    end
  end

  // last m bytes of the text, first byte lowest
  assign recent_new = {s1.text_byte, recent_bytes[WORD_W-1:8]};
  assign sh         = LEN_W'(MAX_WORD_LEN) - m;
  assign text_key   = recent_new >> {sh, 3'b000};

  always_comb begin
    for (int i = 0; i < MAX_WORD_LEN; i++) begin
      load_key[8*i +: 8] = (LEN_W'(i) < m) ? s1.word[8*i +: 8] : 8'h00;
    end
  end

  assign key = is_load ? load_key : text_key;

  assign text_ok  = is_text && (text_position != POS_MAX);
  assign p_inc    = text_position + POS_BITS'(1);
  assign complete = text_ok && (p_inc >= POS_BITS'(m));
  assign j        = p_inc - POS_BITS'(m);
  assign span     = SPAN_W'(total) * SPAN_W'(m);
  assign back     = SPAN_W'(total - CNT_W'(1)) * SPAN_W'(m);
  assign back_ok  = (j >= POS_BITS'(back));
  assign start    = j - POS_BITS'(back);
  assign restart  = cfg_we || (go && (is_clear || is_load || is_restart));

  assign dict_ctl.clear = go && is_clear;
  assign dict_ctl.load  = go && is_load;

  assign win_ctl.restart = restart;
  assign win_ctl.step    = go && complete;
  assign win_ctl.dec_en  = (total != '0) && (j >= POS_BITS'(span));

  wbm_dict u_dict (
    .clk           (clk),
    .rst           (rst),
    .ctl           (dict_ctl),
    .key           (key),
    .cur           (cur),
    .distinct      (distinct),
    .distinct_next (distinct_next),
    .total         (total),
    .full          (full),
    .need          (need)
  );

  wbm_window u_window (
    .clk      (clk),
    .rst      (rst),
    .ctl      (win_ctl),
    .cur      (cur),
    .need     (need),
    .distinct (distinct),
    .m        (m),
    .span     (span),
    .sat_hit  (sat_hit)
  );

  assign found = complete && sat_hit && back_ok;

  always_comb begin
    if (is_load && full) begin
      status = STATUS_DICT_FULL;
    end else if (is_text && !text_ok) begin
      status = STATUS_TEXT_LONG;
    end else begin
      status = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_len      <= LEN_W'(1);
      text_position <= '0;
      recent_bytes  <= '0;
    end else begin
      if (cfg_we) begin
        word_len <= cfg_data;
      end
      if (restart) begin
        text_position <= '0;
        recent_bytes  <= '0;
      end else if (go && text_ok) begin
        text_position <= p_inc;
        recent_bytes  <= recent_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      result.match_found    <= found;
      result.match_start    <= found ? start : '0;
      result.status         <= status;
      result.distinct_words <= distinct_next;
    end
  end

endmodule

>>> design/wbm_checker.sv
module wbm_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       item_valid,
  input logic                       item_stall,
  input logic                       result_valid,
  input logic                       result_stall,
  input wbm_pkg::result_t           result
);
  import wbm_pkg::*;

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result beat changed");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) ##1 (!result_valid || !result_stall) |=> result_valid)
    else $error("accepted item produced no result");

  a_status_no_match: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.status != STATUS_OK)) |-> !result.match_found)
    else $error("match reported on a dropped beat");

  a_start_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.match_found) |-> (result.match_start == '0))
    else $error("match_start set without a match");

endmodule

bind word_bag_window_matcher wbm_checker u_wbm_checker (.*);

>>> sim/tb_top.sv
module tb_top;
  import wbm_pkg::*;

  localparam int CYCLE_LIMIT = 200_000;

  logic              clk;
  logic              rst;
  logic              item_valid;
  logic              item_stall;
  item_t             item;
  logic              result_valid;
  logic              result_stall;
  result_t           result;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [LEN_W-1:0]  cfg_data;

  word_bag_window_matcher u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // matcher state mirror
  logic [LEN_W-1:0]  len_reg;
  logic [WORD_W-1:0] vocab [MAX_WORDS];
  int unsigned       vocab_need [MAX_WORDS];
  int unsigned       n_distinct;
  int unsigned       n_total;
  logic [WORD_W-1:0] shift_bytes;
  int unsigned       text_pos;
  int unsigned       hist_slot [HIST_DEPTH];
  int unsigned       win_cnt [MAX_WORD_LEN][MAX_WORDS];
  int unsigned       phase_hits [MAX_WORD_LEN];

  item_t             pending_items [$];
  result_t           expected_results [$];
  int                send_idle_pct;
  int                recv_stall_pct;
  logic              drain_pause = 1'b0;
  int unsigned       n_shown = 0;
  int unsigned       n_queued;
  int                n_errors = 0;
  int                n_cycles = 0;

  // stimulus generator state
  logic [LEN_W-1:0]  cur_len;
  logic [WORD_W-1:0] bag [$];
  logic [7:0]        alpha0;
  logic [7:0]        alpha1;

  function automatic int unsigned eff_len(input logic [LEN_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_WORD_LEN) return MAX_WORD_LEN;
    return 32'(v);
  endfunction

  function automatic void clear_window();
    shift_bytes = '0;
    text_pos = 0;
    for (int a = 0; a < MAX_WORD_LEN; a++) begin
      phase_hits[a] = 0;
      for (int b = 0; b < MAX_WORDS; b++) win_cnt[a][b] = 0;
    end
  endfunction

  function automatic int unsigned find_vocab(input logic [WORD_W-1:0] w);
    for (int k = 0; k < n_distinct && k < MAX_WORDS; k++)
      if (vocab[k] == w) return k;
    return NO_WORD;
  endfunction

  function automatic result_t match_step(input item_t it);
    result_t           r;
    int unsigned       m, p, j, ph, span, back, cur, prev;
    logic [WORD_W-1:0] w;
    r = '0;
    m = eff_len(len_reg);
    case (it.mode)
      MODE_CLEAR: begin
        n_distinct = 0;
        n_total = 0;
        clear_window();
      end
      MODE_LOAD: begin
        clear_window();
        if (n_total >= MAX_WORDS) begin
          r.status = STATUS_DICT_FULL;
        end else begin
          w = (m >= 8) ? it.word : it.word & ((64'd1 << (8 * m)) - 64'd1);
          cur = find_vocab(w);
          if (cur < MAX_WORDS) begin
            vocab_need[cur]++;
          end else begin
            vocab[n_distinct] = w;
            vocab_need[n_distinct] = 1;
            n_distinct++;
          end
          n_total++;
        end
      end
      MODE_RESTART: clear_window();
      default: begin
        if (text_pos >= POS_MAX) begin
          r.status = STATUS_TEXT_LONG;
        end else begin
          p = text_pos;
          shift_bytes = {it.text_byte, shift_bytes[WORD_W-1:8]};
          text_pos = p + 1;
          if (p + 1 >= m) begin
            j = p + 1 - m;
            ph = j % m;
            span = n_total * m;
            w = shift_bytes >> (64 - 8 * m);
            cur = find_vocab(w);
            // drop the word sliding out of this phase's window
            if (n_total > 0 && j >= span) begin
              prev = hist_slot[(j - span) % HIST_DEPTH];
              if (prev < MAX_WORDS && win_cnt[ph][prev] > 0) begin
                if (win_cnt[ph][prev] == vocab_need[prev] && phase_hits[ph] > 0)
                  phase_hits[ph]--;
                win_cnt[ph][prev]--;
              end
            end
            if (cur < MAX_WORDS) begin
              if (win_cnt[ph][cur] < 255) win_cnt[ph][cur]++;
              if (win_cnt[ph][cur] == vocab_need[cur]) phase_hits[ph]++;
            end
            hist_slot[j % HIST_DEPTH] = cur;
            if (n_distinct > 0 && phase_hits[ph] == n_distinct) begin
              back = (n_total - 1) * m;
              if (j >= back) begin
                r.match_found = 1'b1;
                r.match_start = POS_BITS'(j - back);
              end
            end
          end
        end
      end
    endcase
    r.distinct_words = cnt_t'(n_distinct);
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endfunction

  always @(posedge clk) begin : drive_items
    item_t nxt;
    logic  show;
    if (rst) begin
      item_valid <= 1'b0;
      item <= '0;
      len_reg = LEN_W'(1);
      n_distinct = 0;
      n_total = 0;
      clear_window();
    end else begin
      show = item_valid;
      nxt = item;
      if (cfg_valid && cfg_ready) begin
        len_reg = cfg_data;
        clear_window();
      end
      if (item_valid && !item_stall) begin
        expected_results = {expected_results, match_step(item)};
        show = 1'b0;
      end
      if (drain_pause && !item_valid && expected_results.size() == 0) drain_pause = 1'b0;
      if (!show && !drain_pause && pending_items.size() != 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_items.pop_front();
        show = 1'b1;
        n_shown++;
        if (n_shown % 97 == 0) drain_pause = 1'b1;
      end
      item_valid <= show;
      item <= nxt;
    end
  end

  always @(posedge clk) begin : watch_results
    result_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected");
          n_errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("match_found", 32'(want.match_found), 32'(result.match_found));
          check_field("match_start", 32'(want.match_start), 32'(result.match_start));
          check_field("status", 32'(want.status), 32'(result.status));
          check_field("distinct_words", 32'(want.distinct_words),
                      32'(result.distinct_words));
        end
      end
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic add_item(input logic [1:0] mode, input logic [WORD_W-1:0] data);
    item_t it;
    it.mode = mode;
    it.word = (mode == MODE_LOAD) ? data : {$urandom, $urandom};
    it.text_byte = (mode == MODE_TEXT) ? data[7:0] : 8'($urandom);
    while (pending_items.size() >= 64) @(negedge clk);
    pending_items = {pending_items, it};
    n_queued++;
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || item_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_word_len(input logic [LEN_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cur_len = v;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [WORD_W-1:0] make_word(input int unsigned m);
    logic [WORD_W-1:0] w;
    w = {$urandom, $urandom};
    for (int b = 0; b < m; b++)
      if ($urandom_range(4) != 0) w[8*b +: 8] = $urandom_range(1) ? alpha0 : alpha1;
    return w;
  endfunction

  task automatic add_word_text(input logic [WORD_W-1:0] w, input int unsigned m);
    for (int b = 0; b < m; b++) add_item(MODE_TEXT, WORD_W'(w[8*b +: 8]));
  endtask

  task automatic add_sequence();
    int unsigned       m, n_load, n_text, sent, k, pos;
    logic [WORD_W-1:0] deck [$];
    logic [WORD_W-1:0] w;
    m = eff_len(cur_len);
    if ($urandom_range(9) == 0) begin
      add_item(MODE_CLEAR, '0);
      bag.delete();
      alpha0 = 8'($urandom);
      alpha1 = 8'($urandom);
    end
    if (bag.size() == 0 || $urandom_range(2) == 0) begin
      k = $urandom_range(99);
      n_load = (k < 85) ? $urandom_range(1, 3) :
               (k < 95) ? MAX_WORDS : $urandom_range(MAX_WORDS + 1, MAX_WORDS + 2);
      repeat (n_load) begin
        w = make_word(m);
        add_item(MODE_LOAD, w);
        if (bag.size() < MAX_WORDS) bag = {bag, w};
      end
    end
    n_text = $urandom_range(m, 3 * m + bag.size() * m);
    sent = 0;
    while (sent < n_text) begin
      k = $urandom_range(99);
      if (k < 50) begin
        deck = bag;
        for (int i = deck.size() - 1; i > 0; i--) begin
          pos = $urandom_range(i);
          w = deck[i];
          deck[i] = deck[pos];
          deck[pos] = w;
        end
        foreach (deck[d]) add_word_text(deck[d], m);
        sent += deck.size() * m;
      end else if (k < 75) begin
        add_word_text(bag[$urandom_range(bag.size() - 1)], m);
        sent += m;
      end else if (k < 94) begin
        add_item(MODE_TEXT, WORD_W'($urandom_range(1) ? alpha0 : alpha1));
        sent++;
      end else if (k < 97) begin
        add_item(MODE_TEXT, WORD_W'($urandom));
        sent++;
      end else if (k < 99) begin
        add_item(MODE_RESTART, '0);
      end else begin
        w = make_word(m);
        add_item(MODE_LOAD, w);
        if (bag.size() < MAX_WORDS) bag = {bag, w};
      end
    end
  endtask

  logic [LEN_W-1:0] len_plan [4] = '{4'd0, 4'd15, 4'd8, 4'd1};
  int               send_plan [4] = '{0, 71, 0, 16};
  int               stall_plan [4] = '{0, 0, 71, 16};

  initial begin
    logic [WORD_W-1:0] w;
    logic [LEN_W-1:0]  len_v;
    int                sess;
    int unsigned       mark;
    clk = 1'b0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    n_queued = 0;
    cur_len = 4'd1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // text with an empty dictionary, then all-ones and all-zero words
    add_item(MODE_TEXT, 64'h00);
    add_item(MODE_LOAD, '1);
    add_item(MODE_LOAD, '0);
    add_item(MODE_LOAD, {56'($urandom), 8'hFF});
    add_item(MODE_TEXT, 64'hFF);
    add_item(MODE_TEXT, 64'h00);
    add_item(MODE_TEXT, 64'hFF);
    add_item(MODE_TEXT, 64'hFF);
    add_item(MODE_TEXT, 64'h00);
    // load in the middle of text, then fill past the dictionary limit
    add_item(MODE_LOAD, '0);
    repeat (MAX_WORDS - 3) add_item(MODE_LOAD, {$urandom, $urandom});
    add_item(MODE_TEXT, 64'h00);
    add_item(MODE_RESTART, '0);
    add_item(MODE_TEXT, 64'hFF);
    add_item(MODE_CLEAR, '0);

    // two one-byte words against a short text
    alpha0 = 8'($urandom);
    alpha1 = 8'($urandom);
    w = {$urandom, $urandom};
    w[7:0] = alpha0;
    add_item(MODE_LOAD, w);
    bag = {bag, w};
    w = {$urandom, $urandom};
    w[7:0] = alpha1;
    add_item(MODE_LOAD, w);
    bag = {bag, w};
    for (int i = 0; i < 40; i++)
      add_item(MODE_TEXT, WORD_W'(($urandom_range(7) == 0) ? 8'($urandom) :
                                  ($urandom_range(1) ? alpha0 : alpha1)));
    add_item(MODE_RESTART, '0);

    // longer words against a dictionary loaded under word length 1
    wait_idle();
    write_word_len(4'd2);
    add_item(MODE_TEXT, WORD_W'(alpha0));
    add_item(MODE_TEXT, 64'h00);
    add_item(MODE_TEXT, WORD_W'(alpha1));
    add_item(MODE_TEXT, 64'h00);

    sess = 0;
    for (int ph = 0; ph < 4; ph++) begin
      for (int s = 0; s < 3; s++) begin
        wait_idle();
        send_idle_pct = send_plan[ph];
        recv_stall_pct = stall_plan[ph];
        len_v = (sess < 4) ? len_plan[sess] : LEN_W'($urandom_range(15));
        write_word_len(len_v);
        sess++;
        mark = n_queued;
        if ($urandom_range(3) != 0) begin
          add_item(MODE_CLEAR, '0);
          bag.delete();
          alpha0 = 8'($urandom);
          alpha1 = 8'($urandom);
        end
        while (n_queued - mark < 24) add_sequence();
      end
    end

    wait_idle();
    repeat (6) @(negedge clk);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
